/* hdl/fpcrc_pkg.sv */
// ----------------------------------------------------------------------------
// fpcrc_pkg
// shared types, constants and the crc byte update for the framed packet parser
// ----------------------------------------------------------------------------
`default_nettype none

package fpcrc_pkg;

	localparam logic [7:0]  FIRST_HDR_RESET  = 8'd105;
	localparam logic [7:0]  SECOND_HDR_RESET = 8'd104;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_FIRST_HDR  = 1'b0;
	localparam logic CFG_SECOND_HDR = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT1  = 3'd0,
		PH_HUNT2  = 3'd1,
		PH_LENGTH = 3'd2,
		PH_TYPE   = 3'd3,
		PH_DATA   = 3'd4,
		PH_CRCHI  = 3'd5,
		PH_CRCLO  = 3'd6
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] crc;
		logic [7:0]  crc_hi;
		logic [7:0]  length;
		logic [7:0]  count;
		logic [7:0]  ftype;
	} parse_state_t;

	typedef struct packed {
		logic       payload_valid;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [7:0] frame_type;
		logic [7:0] frame_length;
		logic       frame_done;
		logic       frame_good;
	} result_t;

	// crc-16-ccitt (poly 0x1021), one byte msb first, table-free form
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ {4'h0, x[7:4]};
		return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000}
			^ {8'h00, x};
	endfunction

endpackage

`default_nettype wire

/* hdl/fpcrc_parse.sv */
// ----------------------------------------------------------------------------
// fpcrc_parse
// next-state and result logic of the frame parser for one received byte
// ----------------------------------------------------------------------------
`default_nettype none

module fpcrc_parse
	import fpcrc_pkg::*;
(
	input  wire parse_state_t cur,
	input  wire logic [7:0]   rx_byte,
	input  wire logic [7:0]   first_hdr,
	input  wire logic [7:0]   second_hdr,
	output parse_state_t      nxt,
	output result_t           res
);

	logic [15:0] crc_upd;
	logic [15:0] crc_rx;

	// seed with the init value when starting a frame on the first header
	assign crc_upd = crc_feed((cur.phase == PH_HUNT1) ? CRC_INIT : cur.crc, rx_byte);
	assign crc_rx  = {cur.crc_hi, rx_byte};

	always_comb begin
		nxt = cur;
		res = '0;
		case (cur.phase)
			PH_HUNT1: begin
				if (rx_byte == first_hdr) begin
					nxt.crc   = crc_upd;
					nxt.phase = PH_HUNT2;
				end
			end
			PH_HUNT2: begin
				// a mismatch is not retried as a first header byte
				if (rx_byte == second_hdr) begin
					nxt.crc   = crc_upd;
					nxt.phase = PH_LENGTH;
				end else begin
					nxt.phase = PH_HUNT1;
				end
			end
			PH_LENGTH: begin
				nxt.length = rx_byte;
				nxt.crc    = crc_upd;
				nxt.phase  = PH_TYPE;
			end
			PH_TYPE: begin
				nxt.ftype = rx_byte;
				nxt.crc   = crc_upd;
				nxt.count = 8'd0;
				nxt.phase = (cur.length == 8'd0) ? PH_CRCHI : PH_DATA;
			end
			PH_DATA: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cur.count;
				nxt.crc   = crc_upd;
				nxt.count = cur.count + 8'd1;
				if ((cur.count + 8'd1) >= cur.length) begin
					nxt.phase = PH_CRCHI;
				end
			end
			PH_CRCHI: begin
				nxt.crc_hi = rx_byte;
				nxt.phase  = PH_CRCLO;
			end
			PH_CRCLO: begin
				res.frame_done = 1'b1;
				res.frame_good = (crc_rx == cur.crc);
				nxt.phase      = PH_HUNT1;
			end
			default: begin
				nxt.phase = PH_HUNT1;
			end
		endcase
		res.frame_type   = nxt.ftype;
		res.frame_length = nxt.length;
	end

endmodule

`default_nettype wire

/* hdl/framed_packet_crc16_parser_unit.sv */
// ----------------------------------------------------------------------------
// framed_packet_crc16_parser_unit
// byte-stream frame parser with crc-16-ccitt check, one result per byte
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_ready   rx_byte
//  output    out_valid / out_ready payload_valid, payload_byte, payload_index,
//                                  frame_type, frame_length, frame_done, frame_good
//  config    cfg_we                cfg_index, cfg_data
//
//  one byte per cycle sustained while the output is not stalled; accept to result passes the input and result registers
//  the input register feeds the parser step, which updates the frame state and
//  the result register together; the step is one byte-wide crc update
//  a stalled result register holds the input register, input keeps flowing
//  into a free input register; async reset returns to header hunting
// ----------------------------------------------------------------------------
`default_nettype none

module framed_packet_crc16_parser_unit
	import fpcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            payload_valid,
	output logic [7:0]      payload_byte,
	output logic [7:0]      payload_index,
	output logic [7:0]      frame_type,
	output logic [7:0]      frame_length,
	output logic            frame_done,
	output logic            frame_good,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);

	logic [7:0]   first_hdr_q;
	logic [7:0]   second_hdr_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	result_t      res_s2;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res_nxt;
	logic         adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= FIRST_HDR_RESET;
			second_hdr_q <= SECOND_HDR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_HDR:  first_hdr_q  <= cfg_data;
				CFG_SECOND_HDR: second_hdr_q <= cfg_data;
				default:        ;
			endcase
		end
	end

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	fpcrc_parse u_parse (
		.cur        (state_q),
		.rx_byte    (byte_s1),
		.first_hdr  (first_hdr_q),
		.second_hdr (second_hdr_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase  <= PH_HUNT1;
			state_q.crc    <= CRC_INIT;
			state_q.crc_hi <= 8'd0;
			state_q.length <= 8'd0;
			state_q.count  <= 8'd0;
			state_q.ftype  <= 8'd0;
			valid_s2       <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign payload_valid = res_s2.payload_valid;
	assign payload_byte  = res_s2.payload_byte;
	assign payload_index = res_s2.payload_index;
	assign frame_type    = res_s2.frame_type;
	assign frame_length  = res_s2.frame_length;
	assign frame_done    = res_s2.frame_done;
	assign frame_good    = res_s2.frame_good;

endmodule

`default_nettype wire

/* dv/fpcrc_check_pkg.sv */
// ----------------------------------------------------------------------------
// fpcrc_check_pkg
// frame parser prediction and result checking for the packet parser bench
// ----------------------------------------------------------------------------
package fpcrc_check_pkg;

	import fpcrc_pkg::*;

	localparam logic [15:0] CCITT_POLY = 16'h1021;

	typedef logic [7:0] byte_q_t[$];

	class frame_checker;

		phase_t      phase;
		logic [15:0] crc;
		logic [7:0]  crc_hi;
		logic [7:0]  length;
		logic [7:0]  count;
		logic [7:0]  ftype;
		logic [7:0]  hdr1;
		logic [7:0]  hdr2;
		result_t     expected_q[$];
		int          errors;
		int          bytes_seen;
		int          results_seen;
		int          frames_done;
		int          frames_good;
		int          payload_seen;

		function new();
			phase = PH_HUNT1;
			crc = CRC_INIT;
			crc_hi = '0;
			length = '0;
			count = '0;
			ftype = '0;
			hdr1 = FIRST_HDR_RESET;
			hdr2 = SECOND_HDR_RESET;
			errors = 0;
			bytes_seen = 0;
			results_seen = 0;
			frames_done = 0;
			frames_good = 0;
			payload_seen = 0;
		endfunction

		// bitwise msb-first update, poly 0x1021, no reflection
		static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
			logic [15:0] r;
			r = c ^ {b, 8'h00};
			for (int i = 0; i < 8; i++)
				r = r[15] ? ((r << 1) ^ CCITT_POLY) : (r << 1);
			return r;
		endfunction

		function void set_header(input logic idx, input logic [7:0] v);
			if (idx == CFG_FIRST_HDR) begin
				hdr1 = v;
			end else begin
				hdr2 = v;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// advance the parser by one accepted byte and queue the result it causes
		function void note_byte(input logic [7:0] b);
			result_t r;
			r = '0;
			case (phase)
				PH_HUNT1: begin
					if (b == hdr1) begin
						crc = crc_step(CRC_INIT, b);
						phase = PH_HUNT2;
					end
				end
				PH_HUNT2: begin
					// a mismatch here is not retried as a first header byte
					if (b == hdr2) begin
						crc = crc_step(crc, b);
						phase = PH_LENGTH;
					end else begin
						phase = PH_HUNT1;
					end
				end
				PH_LENGTH: begin
					length = b;
					crc = crc_step(crc, b);
					phase = PH_TYPE;
				end
				PH_TYPE: begin
					ftype = b;
					crc = crc_step(crc, b);
					count = '0;
					phase = (length == 8'd0) ? PH_CRCHI : PH_DATA;
				end
				PH_DATA: begin
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = count;
					crc = crc_step(crc, b);
					count = count + 8'd1;
					if (count >= length)
						phase = PH_CRCHI;
				end
				PH_CRCHI: begin
					crc_hi = b;
					phase = PH_CRCLO;
				end
				PH_CRCLO: begin
					r.frame_done = 1'b1;
					r.frame_good = ({crc_hi, b} == crc);
					phase = PH_HUNT1;
				end
				default: begin
					phase = PH_HUNT1;
				end
			endcase
			r.frame_type = ftype;
			r.frame_length = length;
			expected_q.push_back(r);
			bytes_seen++;
		endfunction

		function void check_field(input string name, input logic [7:0] want,
				input logic [7:0] got, input longint stamp);
			if (got !== want) begin
				errors++;
				$display("%0d ns: %s mismatch, expected %0h, actual %0h", stamp, name, want, got);
			end
		endfunction

		function void check_result(input result_t got, input longint stamp);
			result_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0d ns: unexpected result, expected none, actual %p", stamp, got);
				return;
			end
			want = expected_q.pop_front();
			results_seen++;
			if (want.frame_done)
				frames_done++;
			if (want.frame_good)
				frames_good++;
			if (want.payload_valid)
				payload_seen++;
			check_field("payload_valid", want.payload_valid, got.payload_valid, stamp);
			check_field("payload_byte", want.payload_byte, got.payload_byte, stamp);
			check_field("payload_index", want.payload_index, got.payload_index, stamp);
			check_field("frame_type", want.frame_type, got.frame_type, stamp);
			check_field("frame_length", want.frame_length, got.frame_length, stamp);
			check_field("frame_done", want.frame_done, got.frame_done, stamp);
			check_field("frame_good", want.frame_good, got.frame_good, stamp);
		endfunction

	endclass

endpackage

/* dv/tb_framed_packet_crc16_parser_unit.sv */
// ----------------------------------------------------------------------------
// tb_framed_packet_crc16_parser_unit
// byte stream regression for the framed packet parser: directed frames and
// header corner cases, then random frames, noise and cut frames under several
// header settings, with random stalls on both channels outside the steady phase and checked results
// ----------------------------------------------------------------------------
module tb_framed_packet_crc16_parser_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import fpcrc_pkg::*;
	import fpcrc_check_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT    = 34;
	localparam int PHASE_ITEMS = 100;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [7:0] payload_index;
	logic [7:0] frame_type;
	logic [7:0] frame_length;
	logic       frame_done;
	logic       frame_good;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'h00;

	logic       steady = 1'b0;
	logic [7:0] cur_h1 = FIRST_HDR_RESET;
	logic [7:0] cur_h2 = SECOND_HDR_RESET;
	int         sent = 0;
	int         settings = 1;
	int         cycles = 0;

	frame_checker sb = new();

	framed_packet_crc16_parser_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.payload_valid(payload_valid),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.frame_type(frame_type),
		.frame_length(frame_length),
		.frame_done(frame_done),
		.frame_good(frame_good),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
	end

	// result transactions
	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.payload_valid = payload_valid;
			got.payload_byte = payload_byte;
			got.payload_index = payload_index;
			got.frame_type = frame_type;
			got.frame_length = frame_length;
			got.frame_done = frame_done;
			got.frame_good = frame_good;
			sb.check_result(got, $time);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(2)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(b);
		sent++;
	endtask

	task automatic send_bytes(input byte_q_t q, input int n);
		for (int i = 0; i < n && i < q.size(); i++)
			send_byte(q[i]);
	endtask

	function automatic void build_frame(input logic [7:0] len, input logic [7:0] ftype,
			input bit const_fill, input logic [7:0] fill, input bit bad_crc,
			output byte_q_t q);
		logic [15:0] c;
		logic [7:0]  b;
		q = {};
		q.push_back(cur_h1);
		q.push_back(cur_h2);
		q.push_back(len);
		q.push_back(ftype);
		for (int i = 0; i < len; i++) begin
			b = const_fill ? fill : 8'($urandom_range(255));
			q.push_back(b);
		end
		c = CRC_INIT;
		foreach (q[i])
			c = frame_checker::crc_step(c, q[i]);
		if (bad_crc)
			c = c ^ 16'($urandom_range(1, 16'hFFFF));
		q.push_back(c[15:8]);
		q.push_back(c[7:0]);
	endfunction

	// drop valid and let every outstanding result drain before touching config
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FIRST_HDR;
		cfg_data <= h1;
		sb.set_header(CFG_FIRST_HDR, h1);
		@(negedge clk);
		cfg_index <= CFG_SECOND_HDR;
		cfg_data <= h2;
		sb.set_header(CFG_SECOND_HDR, h2);
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_h1 = h1;
		cur_h2 = h2;
		settings++;
	endtask

	task automatic run_traffic(input int budget, input bit with_long);
		int         target;
		int         pick;
		logic [7:0] len;
		byte_q_t    q;
		if (with_long) begin
			build_frame(8'd255, 8'($urandom_range(255)), 1'b0, 8'h00, 1'b0, q);
			send_bytes(q, q.size());
		end
		target = sent + budget;
		while (sent < target) begin
			pick = $urandom_range(99);
			len = ($urandom_range(29) == 0) ? 8'($urandom_range(9, 64)) : 8'($urandom_range(8));
			if (pick < 70) begin
				build_frame(len, 8'($urandom_range(255)), 1'b0, 8'h00,
					$urandom_range(99) < 15, q);
				send_bytes(q, q.size());
			end else if (pick < 85) begin
				// noise, sometimes carrying a lone first header byte
				repeat ($urandom_range(1, 4))
					send_byte(($urandom_range(3) == 0) ? cur_h1 : 8'($urandom_range(255)));
			end else if (pick < 95) begin
				// cut frame: following bytes are taken as its continuation
				build_frame(len, 8'($urandom_range(255)), 1'b0, 8'h00, 1'b0, q);
				send_bytes(q, $urandom_range(1, q.size() - 1));
			end else begin
				send_byte(cur_h1);
				send_byte(cur_h2 ^ 8'($urandom_range(1, 255)));
			end
		end
		settle();
	endtask

	initial begin
		byte_q_t    q;
		logic [7:0] h;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero length frame, good crc, type at its top value
		build_frame(8'd0, 8'hFF, 1'b1, 8'h00, 1'b0, q);
		send_bytes(q, q.size());
		// second header wrong but equal to the first one, then a bare second header
		send_byte(cur_h1);
		send_byte(cur_h1);
		send_byte(cur_h2);
		// two payload bytes at the top value, type zero
		build_frame(8'd2, 8'h00, 1'b1, 8'hFF, 1'b0, q);
		send_bytes(q, q.size());
		// zero length frame with a broken crc
		build_frame(8'd0, 8'h5A, 1'b1, 8'h00, 1'b1, q);
		send_bytes(q, q.size());
		// idle bytes between frames keep the last type and length
		send_byte(8'h00);
		send_byte(8'hFF);
		settle();

		set_headers(8'h00, 8'hFF);
		run_traffic(PHASE_ITEMS, 1'b1);

		set_headers(8'hFF, 8'h00);
		steady <= 1'b1;
		run_traffic(PHASE_ITEMS, 1'b0);
		steady <= 1'b0;

		h = $urandom_range(255);
		set_headers(h, h);
		run_traffic(PHASE_ITEMS, 1'b0);

		set_headers($urandom_range(255), $urandom_range(255));
		run_traffic(PHASE_ITEMS, 1'b0);

		set_headers(FIRST_HDR_RESET, SECOND_HDR_RESET);
		run_traffic(PHASE_ITEMS, 1'b0);

		repeat (10) @(posedge clk);
		$display("covered %0d bytes and %0d results over %0d header settings",
			sb.bytes_seen, sb.results_seen, settings);
		$display("%0d frames closed, %0d with matching crc, %0d payload bytes",
			sb.frames_done, sb.frames_good, sb.payload_seen);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
